// ===== hdl/fixed_partition_fit_allocator_top_defines.svh =====
// Assertion macros for the partition fit allocator.
// Expects clk and rst in the scope of the including module.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FPFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fpfa_pkg.sv =====
// Shared constants and types for the partition fit allocator.
// No dependencies; used by fpfa_cell and the top level.
package fpfa_pkg;

  localparam int PARTITION_COUNT_DEF = 16;
  localparam int SIZE_BITS_DEF       = 16;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int AMOUNT_W   = 16;
  localparam int WASTE_W    = 20;
  localparam int POLICY_W   = 2;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTS_USED = 2'd1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 5'd16;
  localparam logic [WASTE_W-1:0]  WASTE_MAX   = 20'hFFFFF;
  localparam logic [AMOUNT_W-1:0] LEFT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

// ===== hdl/fpfa_cell.sv =====
// One partition cell: size entry, used flag and one stage of the search token.
// Depends on fpfa_pkg.
module fpfa_cell #(
  parameter int CELL_INDEX = 0,
  parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fpfa_pkg::POLICY_W-1:0]   policy,
  input  logic [fpfa_pkg::LIMIT_W-1:0]    limit,
  input  logic                            wr_en,
  input  logic [fpfa_pkg::SLOT_W-1:0]     wr_slot,
  input  logic [SIZE_BITS-1:0]            wr_size,
  input  logic                            clr,
  input  logic                            mark_en,
  input  logic [IDX_W-1:0]                mark_idx,
  input  fpfa_pkg::tok_ctl_t              ctl_in,
  input  logic [IDX_W-1:0]                idx_in,
  input  logic [SIZE_BITS-1:0]            size_in,
  input  logic [fpfa_pkg::AMOUNT_W-1:0]   req_in,
  output fpfa_pkg::tok_ctl_t              ctl_out,
  output logic [IDX_W-1:0]                idx_out,
  output logic [SIZE_BITS-1:0]            size_out,
  output logic [fpfa_pkg::AMOUNT_W-1:0]   req_out
);

  localparam int CMP_W = (SIZE_BITS > fpfa_pkg::AMOUNT_W) ? SIZE_BITS : fpfa_pkg::AMOUNT_W;
  localparam logic [31:0]      MY_POS = 32'(CELL_INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [SIZE_BITS-1:0] part_size;
  logic                 used;
  logic                 here_wr;
  logic                 here_mark;
  logic                 in_range;
  logic                 fits;
  logic                 better;
  logic                 take;

  assign here_wr   = wr_en && (32'(wr_slot) == MY_POS);
  assign here_mark = mark_en && (32'(mark_idx) == MY_POS);
  assign in_range  = 32'(limit) > MY_POS;
  assign fits      = CMP_W'(part_size) >= CMP_W'(req_in);
  assign better    = !ctl_in.found
                  || ((policy == fpfa_pkg::POLICY_BEST) && (part_size < size_in))
                  || ((policy == fpfa_pkg::POLICY_WORST) && (part_size > size_in));
  assign take      = ctl_in.valid && in_range && !used && fits && better;

  always_ff @(posedge clk) begin
    if (here_wr) begin
      part_size <= wr_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (clr) begin
      used <= 1'b0;
    end else if (here_mark) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.found <= ctl_in.found | take;
    end
    idx_out  <= take ? MY_IDX : idx_in;
    size_out <= take ? part_size : size_in;
    req_out  <= req_in;
  end

endmodule

// ===== hdl/fixed_partition_fit_allocator_top.sv =====
// Partition fit allocator top level: config registers, control FSM, cell row.
// Depends on fpfa_pkg, fpfa_cell and fixed_partition_fit_allocator_top_defines.svh.
//
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   op, slot, amount
// out      out  out_valid / out_ready granted, chosen_slot, leftover, total_waste
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Allocate: the search token walks the cell row one cell per cycle; the scan state
// then captures the token and the put state registers the result once the output is free.
// Load, clear and unknown ops go from accept to the put state, which registers the result.
// A new item is taken once the previous result is registered; it may be accepted
// while that result still waits on out_ready. Reset clears used flags, waste sum
// and config; size entries are not cleared. cfg_ready is always high.
`include "fixed_partition_fit_allocator_top_defines.svh"

module fixed_partition_fit_allocator_top #(
  parameter int PARTITION_COUNT = fpfa_pkg::PARTITION_COUNT_DEF,
  parameter int SIZE_BITS       = fpfa_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fpfa_pkg::OP_W-1:0]         op,
  input  logic [fpfa_pkg::SLOT_W-1:0]       slot,
  input  logic [fpfa_pkg::AMOUNT_W-1:0]     amount,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              granted,
  output logic [fpfa_pkg::SLOT_W-1:0]       chosen_slot,
  output logic [fpfa_pkg::AMOUNT_W-1:0]     leftover,
  output logic [fpfa_pkg::WASTE_W-1:0]      total_waste,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
  localparam int DIFF_W = (SIZE_BITS > fpfa_pkg::AMOUNT_W) ? SIZE_BITS : fpfa_pkg::AMOUNT_W;
  localparam int SUM_W = ((DIFF_W > fpfa_pkg::WASTE_W) ? DIFF_W : fpfa_pkg::WASTE_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT
  } state_t;

  state_t                          state;
  logic [fpfa_pkg::POLICY_W-1:0]   policy;
  logic [fpfa_pkg::LIMIT_W-1:0]    limit;
  logic [fpfa_pkg::WASTE_W-1:0]    waste;
  logic                            pend_found;
  logic [IDX_W-1:0]                pend_idx;
  logic [SIZE_BITS-1:0]            pend_size;
  logic [fpfa_pkg::AMOUNT_W-1:0]   pend_req;

  fpfa_pkg::tok_ctl_t              tok_ctl  [0:PARTITION_COUNT];
  logic [IDX_W-1:0]                tok_idx  [0:PARTITION_COUNT];
  logic [SIZE_BITS-1:0]            tok_size [0:PARTITION_COUNT];
  logic [fpfa_pkg::AMOUNT_W-1:0]   tok_req  [0:PARTITION_COUNT];

  logic                            in_fire;
  logic                            out_free;
  logic                            put_fire;
  logic                            wr_en;
  logic                            clr;
  logic                            mark_en;
  logic                            tok_busy;
  logic [DIFF_W-1:0]               diff;
  logic [SUM_W-1:0]                sum;
  logic [fpfa_pkg::WASTE_W-1:0]    waste_next;
  logic [fpfa_pkg::AMOUNT_W-1:0]   left_sat;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign put_fire  = (state == ST_PUT) && out_free;
  assign wr_en     = in_fire && (op == fpfa_pkg::OP_LOAD);
  assign clr       = in_fire && (op == fpfa_pkg::OP_CLEAR);
  assign mark_en   = put_fire && pend_found;

  assign tok_ctl[0]  = '{valid: in_fire && (op == fpfa_pkg::OP_ALLOC), found: 1'b0};
  assign tok_idx[0]  = '0;
  assign tok_size[0] = '0;
  assign tok_req[0]  = amount;

  for (genvar i = 0; i < PARTITION_COUNT; i++) begin : g_cell
    fpfa_cell #(
      .CELL_INDEX (i),
      .SIZE_BITS  (SIZE_BITS),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .policy   (policy),
      .limit    (limit),
      .wr_en    (wr_en),
      .wr_slot  (slot),
      .wr_size  (SIZE_BITS'(amount)),
      .clr      (clr),
      .mark_en  (mark_en),
      .mark_idx (pend_idx),
      .ctl_in   (tok_ctl[i]),
      .idx_in   (tok_idx[i]),
      .size_in  (tok_size[i]),
      .req_in   (tok_req[i]),
      .ctl_out  (tok_ctl[i+1]),
      .idx_out  (tok_idx[i+1]),
      .size_out (tok_size[i+1]),
      .req_out  (tok_req[i+1])
    );
  end

  always_comb begin
    tok_busy = 1'b0;
    for (int i = 1; i <= PARTITION_COUNT; i++) begin
      tok_busy = tok_busy | tok_ctl[i].valid;
    end
  end

  assign diff       = DIFF_W'(pend_size) - DIFF_W'(pend_req);
  assign sum        = SUM_W'(waste) + SUM_W'(diff);
  assign waste_next = (sum > SUM_W'(fpfa_pkg::WASTE_MAX)) ? fpfa_pkg::WASTE_MAX
                                                          : sum[fpfa_pkg::WASTE_W-1:0];
  assign left_sat   = (diff > DIFF_W'(fpfa_pkg::LEFT_MAX)) ? fpfa_pkg::LEFT_MAX
                                                           : diff[fpfa_pkg::AMOUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      waste     <= '0;
      policy    <= fpfa_pkg::POLICY_FIRST;
      limit     <= fpfa_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid && (cfg_index == fpfa_pkg::REG_FIT_POLICY)) begin
        policy <= cfg_data[fpfa_pkg::POLICY_W-1:0];
      end
      if (cfg_valid && (cfg_index == fpfa_pkg::REG_PARTS_USED)) begin
        limit <= cfg_data[fpfa_pkg::LIMIT_W-1:0];
      end
      if (out_valid && out_ready && !put_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            pend_found <= 1'b0;
            if (op == fpfa_pkg::OP_ALLOC) begin
              state <= ST_SCAN;
            end else begin
              if (op == fpfa_pkg::OP_CLEAR) begin
                waste <= '0;
              end
              state <= ST_PUT;
            end
          end
        end
        ST_SCAN: begin
          if (tok_ctl[PARTITION_COUNT].valid) begin
            pend_found <= tok_ctl[PARTITION_COUNT].found;
            pend_idx   <= tok_idx[PARTITION_COUNT];
            pend_size  <= tok_size[PARTITION_COUNT];
            pend_req   <= tok_req[PARTITION_COUNT];
            state      <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            granted     <= pend_found;
            chosen_slot <= pend_found ? fpfa_pkg::SLOT_W'(pend_idx) : '0;
            leftover    <= pend_found ? left_sat : '0;
            total_waste <= pend_found ? waste_next : waste;
            if (pend_found) begin
              waste <= waste_next;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FPFA_ASSERT_SAME(a_token_only_in_scan, tok_busy, state == ST_SCAN, "search token outside scan")
  `FPFA_ASSERT_SAME(a_grant_fits, (state == ST_PUT) && pend_found, DIFF_W'(pend_size) >= DIFF_W'(pend_req), "granted partition smaller than request")
  `FPFA_ASSERT_NEXT(a_waste_grows, state != ST_IDLE, waste >= $past(waste), "waste sum dropped outside a clear")
  `FPFA_ASSERT_NEXT(a_put_drives_out, put_fire, out_valid && (state == ST_IDLE), "result beat not presented after put")

endmodule
